// ----- hw/rtl/radial_gradient_pixel_unit_assert.svh -----
// Assertion macros for the radial gradient pixel unit.
// Depends on nothing; included by the top level only.
`ifndef RADIAL_GRADIENT_PIXEL_UNIT_ASSERT_SVH
`define RADIAL_GRADIENT_PIXEL_UNIT_ASSERT_SVH

// Same-cycle implication under reset.
`define RGP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgp assertion failed");

// Next-cycle implication under reset.
`define RGP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgp assertion failed");

`endif

// ----- hw/rtl/rgp_pkg.sv -----
// Shared types and constants of the radial gradient pixel unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgp_pkg;

    localparam int COORD_W      = 10;
    localparam int RADIUS_W     = 11;
    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 3;
    localparam int SQ_PAIRS     = 11;
    localparam int D2_W         = 2 * SQ_PAIRS;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END   = 3'd4;

    localparam logic [COORD_W-1:0]  CENTER_ROW_RST  = 10'd512;
    localparam logic [COORD_W-1:0]  CENTER_COL_RST  = 10'd512;
    localparam logic [RADIUS_W-1:0] RADIUS_RST      = 11'd256;
    localparam logic [COLOR_W-1:0]  COLOR_START_RST = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0]  COLOR_END_RST   = 24'h000000;
    localparam logic [D2_W-1:0]     RADIUS_SQ_RST   = 22'd65536;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Classified pixel: squared distance and the "at or beyond radius" flag
    typedef struct packed {
        logic [D2_W-1:0] d2;
        logic            sat;
    } item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic [D2_W-1:0]    radius_sq;
    } geom_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgp_front.sv -----
// Front end: accepts pixel coordinates, forms the squared distance and
// the saturation flag over two stages. Uses rgp_pkg.
`default_nettype none

module rgp_front (
    input  wire logic                        clk,
    input  wire logic                        rstn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rgp_pkg::COORD_W-1:0] pixel_row,
    input  wire logic [rgp_pkg::COORD_W-1:0] pixel_col,
    input  wire rgp_pkg::geom_t              geom,
    input  wire logic                        q_full,
    output logic                             push,
    output rgp_pkg::item_t                   item
);
    import rgp_pkg::*;

    logic               f1_vld_reg;
    logic               f2_vld_reg;
    logic [COORD_W-1:0] dr_reg;
    logic [COORD_W-1:0] dc_reg;
    logic [D2_W-1:0]    d2_reg;
    logic               sat_reg;
    logic               fen;
    logic [COORD_W-1:0] dr_next;
    logic [COORD_W-1:0] dc_next;
    logic [D2_W-1:0]    d2_next;

    // advance the whole front unless the last stage is held by a full queue
    assign fen     = !f2_vld_reg || !q_full;
    assign s_ready = fen;
    assign push    = f2_vld_reg && !q_full;
    assign item    = '{d2: d2_reg, sat: sat_reg};

    always_comb begin
        dr_next = (pixel_row >= geom.center_row) ? pixel_row - geom.center_row
                                                 : geom.center_row - pixel_row;
        dc_next = (pixel_col >= geom.center_col) ? pixel_col - geom.center_col
                                                 : geom.center_col - pixel_col;
        d2_next = D2_W'(dr_reg) * D2_W'(dr_reg) + D2_W'(dc_reg) * D2_W'(dc_reg);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (fen) begin
            f1_vld_reg <= s_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (fen) begin
            dr_reg  <= dr_next;
            dc_reg  <= dc_next;
            d2_reg  <= d2_next;
            sat_reg <= d2_next >= geom.radius_sq;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgp_queue.sv -----
// Short queue between the front end and the back end.
// Uses rgp_pkg for the item and status types.
`default_nettype none

module rgp_queue (
    input  wire logic               clk,
    input  wire logic               rstn,
    input  wire logic               push,
    input  wire rgp_pkg::item_t     push_item,
    input  wire logic               pop,
    output rgp_pkg::item_t          head,
    output rgp_pkg::q_status_t      status
);
    import rgp_pkg::*;

    item_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign status.empty = count_reg == '0;
    assign status.count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgp_back.sv -----
// Back end: pipelined scaled square root, restoring divide by the radius,
// per-channel multiply and blend into the output register. Uses rgp_pkg.
`default_nettype none

module rgp_back #(
    parameter int FRAC_BITS = rgp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rstn,
    input  wire rgp_pkg::item_t               head,
    input  wire logic                         head_valid,
    output logic                              pop,
    input  wire logic [rgp_pkg::RADIUS_W-1:0] radius,
    input  wire logic [rgp_pkg::COLOR_W-1:0]  color_start,
    input  wire logic [rgp_pkg::COLOR_W-1:0]  color_end,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [rgp_pkg::CHAN_W-1:0]        m_red,
    output logic [rgp_pkg::CHAN_W-1:0]        m_green,
    output logic [rgp_pkg::CHAN_W-1:0]        m_blue
);
    import rgp_pkg::*;

    localparam int ROOT_W = SQ_PAIRS + FRAC_BITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int K_W    = FRAC_BITS + 1;
    localparam int PROD_W = CHAN_W + K_W;
    localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'((1 << FRAC_BITS) - 1);

    logic adv;

    logic              sq_vld  [ROOT_W];
    logic [D2_W-1:0]   sq_d2   [ROOT_W];
    logic              sq_sat  [ROOT_W];
    logic [REM_W-1:0]  sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] sq_root [ROOT_W];

    logic                 dv_vld [FRAC_BITS];
    logic                 dv_sat [FRAC_BITS];
    logic [ROOT_W-1:0]    dv_m   [FRAC_BITS];
    logic [RADIUS_W-1:0]  dv_rem [FRAC_BITS];
    logic [FRAC_BITS-1:0] dv_q   [FRAC_BITS];

    logic              mul_vld_reg;
    logic [PROD_W-1:0] mul_prod_reg [NUM_CHAN];
    logic              mul_neg_reg  [NUM_CHAN];
    logic [CHAN_W-1:0] mul_from_reg [NUM_CHAN];

    logic              m_vld_reg;
    logic [CHAN_W-1:0] out_reg [NUM_CHAN];

    logic [K_W-1:0]    k;

    // the whole back end moves only when the output register can take a result
    assign adv = !m_vld_reg || m_ready;
    assign pop = adv && head_valid;

    // one root bit per stage
    for (genvar i = 0; i < ROOT_W; i++) begin : g_sq
        logic              src_vld;
        logic [D2_W-1:0]   src_d2;
        logic              src_sat;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0) begin : g_src
            assign src_vld  = head_valid;
            assign src_d2   = head.d2;
            assign src_sat  = head.sat;
            assign src_rem  = '0;
            assign src_root = '0;
        end else begin : g_src
            assign src_vld  = sq_vld[i-1];
            assign src_d2   = sq_d2[i-1];
            assign src_sat  = sq_sat[i-1];
            assign src_rem  = sq_rem[i-1];
            assign src_root = sq_root[i-1];
        end

        if (i < SQ_PAIRS) begin : g_pair
            assign pair = src_d2[2*(SQ_PAIRS-1-i) +: 2];
        end else begin : g_pair
            assign pair = 2'b00;
        end

        assign rem_sh = {src_rem[REM_W-3:0], pair};
        assign trial  = {src_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk) begin
            if (!rstn) begin
                sq_vld[i] <= 1'b0;
            end else if (adv) begin
                sq_vld[i] <= src_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                sq_d2[i]   <= src_d2;
                sq_sat[i]  <= src_sat;
                sq_rem[i]  <= ge ? rem_sh - trial : rem_sh;
                sq_root[i] <= {src_root[ROOT_W-2:0], ge};
            end
        end
    end

    // one quotient bit per stage; quotient stays below 1.0 unless saturated
    for (genvar j = 0; j < FRAC_BITS; j++) begin : g_dv
        logic                 src_vld;
        logic                 src_sat;
        logic [ROOT_W-1:0]    src_m;
        logic [RADIUS_W-1:0]  src_rem;
        logic [FRAC_BITS-1:0] src_q;
        logic [RADIUS_W:0]    r2;
        logic                 ge;

        if (j == 0) begin : g_src
            assign src_vld = sq_vld[ROOT_W-1];
            assign src_sat = sq_sat[ROOT_W-1];
            assign src_m   = sq_root[ROOT_W-1];
            assign src_rem = RADIUS_W'(sq_root[ROOT_W-1] >> FRAC_BITS);
            assign src_q   = '0;
        end else begin : g_src
            assign src_vld = dv_vld[j-1];
            assign src_sat = dv_sat[j-1];
            assign src_m   = dv_m[j-1];
            assign src_rem = dv_rem[j-1];
            assign src_q   = dv_q[j-1];
        end

        assign r2 = {src_rem, src_m[FRAC_BITS-1-j]};
        assign ge = r2 >= {1'b0, radius};

        always_ff @(posedge clk) begin
            if (!rstn) begin
                dv_vld[j] <= 1'b0;
            end else if (adv) begin
                dv_vld[j] <= src_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (adv) begin
                dv_sat[j] <= src_sat;
                dv_m[j]   <= src_m;
                dv_rem[j] <= ge ? RADIUS_W'(r2 - {1'b0, radius}) : RADIUS_W'(r2);
                dv_q[j]   <= {src_q[FRAC_BITS-2:0], ge};
            end
        end
    end

    assign k = dv_sat[FRAC_BITS-1] ? {1'b1, {FRAC_BITS{1'b0}}}
                                   : {1'b0, dv_q[FRAC_BITS-1]};

    always_ff @(posedge clk) begin
        if (!rstn) begin
            mul_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else if (adv) begin
            mul_vld_reg <= dv_vld[FRAC_BITS-1];
            m_vld_reg   <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        logic [CHAN_W-1:0] from_c;
        logic [CHAN_W-1:0] to_c;
        logic              neg;
        if (adv) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                from_c = color_start[(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W];
                to_c   = color_end[(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W];
                neg    = to_c < from_c;
                mul_neg_reg[ch]  <= neg;
                mul_from_reg[ch] <= from_c;
                mul_prod_reg[ch] <= (neg ? from_c - to_c : to_c - from_c) * k;
            end
        end
    end

    // round the step toward minus infinity: up when descending
    always_ff @(posedge clk) begin
        if (adv) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                out_reg[ch] <= mul_neg_reg[ch]
                    ? mul_from_reg[ch] - CHAN_W'((mul_prod_reg[ch] + ROUND_UP) >> FRAC_BITS)
                    : mul_from_reg[ch] + CHAN_W'(mul_prod_reg[ch] >> FRAC_BITS);
            end
        end
    end

    assign m_valid = m_vld_reg;
    assign m_red   = out_reg[0];
    assign m_green = out_reg[1];
    assign m_blue  = out_reg[2];

endmodule

`default_nettype wire

// ----- hw/rtl/radial_gradient_pixel_unit.sv -----
// Radial gradient pixel unit: one pixel per clock when not stalled.
// Latency is set by the bit-per-stage square root and divide pipelines.
// Throughput: one pixel per cycle, sustained while the result side takes.
// Reset (aresetn low, synchronous) empties all stages and the queue and
// loads center 512/512, radius 256, start white, end black.
`default_nettype none

`include "radial_gradient_pixel_unit_assert.svh"

module radial_gradient_pixel_unit #(
    parameter int FRAC_BITS = rgp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rgp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [rgp_pkg::COORD_W-1:0]    s_pixel_row,
    input  wire logic [rgp_pkg::COORD_W-1:0]    s_pixel_col,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [rgp_pkg::CHAN_W-1:0]          m_red,
    output logic [rgp_pkg::CHAN_W-1:0]          m_green,
    output logic [rgp_pkg::CHAN_W-1:0]          m_blue
);
    import rgp_pkg::*;

    logic [COORD_W-1:0]  center_row_reg;
    logic [COORD_W-1:0]  center_col_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [COLOR_W-1:0]  color_start_reg;
    logic [COLOR_W-1:0]  color_end_reg;
    logic [D2_W-1:0]     radius_sq_reg;

    geom_t     geom;
    item_t     f_item;
    item_t     q_head;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;

    assign cfg_ready = 1'b1;
    assign geom      = '{center_row: center_row_reg, center_col: center_col_reg,
                         radius_sq: radius_sq_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_row_reg  <= CENTER_ROW_RST;
            center_col_reg  <= CENTER_COL_RST;
            radius_reg      <= RADIUS_RST;
            color_start_reg <= COLOR_START_RST;
            color_end_reg   <= COLOR_END_RST;
            radius_sq_reg   <= RADIUS_SQ_RST;
        end else begin
            radius_sq_reg <= D2_W'(radius_reg) * D2_W'(radius_reg);
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_CENTER_ROW:  center_row_reg  <= cfg_data[COORD_W-1:0];
                    CFG_CENTER_COL:  center_col_reg  <= cfg_data[COORD_W-1:0];
                    CFG_RADIUS:      radius_reg      <= cfg_data[RADIUS_W-1:0];
                    CFG_COLOR_START: color_start_reg <= cfg_data[COLOR_W-1:0];
                    CFG_COLOR_END:   color_end_reg   <= cfg_data[COLOR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    rgp_front u_front (
        .clk       (aclk),
        .rstn      (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .pixel_row (s_pixel_row),
        .pixel_col (s_pixel_col),
        .geom      (geom),
        .q_full    (q_stat.full),
        .push      (q_push),
        .item      (f_item)
    );

    rgp_queue u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (q_push),
        .push_item (f_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_stat)
    );

    rgp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (aclk),
        .rstn        (aresetn),
        .head        (q_head),
        .head_valid  (!q_stat.empty),
        .pop         (q_pop),
        .radius      (radius_reg),
        .color_start (color_start_reg),
        .color_end   (color_end_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue)
    );

    `RGP_ASSERT_IMPLY(a_q_bound, aclk, aresetn, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
    `RGP_ASSERT_IMPLY(a_no_push_full, aclk, aresetn, q_push, !q_stat.full)
    `RGP_ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, q_pop, !q_stat.empty)
    `RGP_ASSERT_NEXT(a_full_holds, aclk, aresetn, q_stat.full && !q_pop, q_stat.full)

endmodule

`default_nettype wire
